[sv/cdc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and calendar arithmetic for the calendar date converter.
// No dependencies; every other file refers to it by scoped names.
package cdc_pkg;

	// Epoch and supported span
	localparam int BASE_YEAR     = 1970;
	localparam int EPOCH_WEEKDAY = 4;
	localparam int YEAR_SPAN     = 256;

	// Field widths
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 17;
	localparam int WDAY_W  = 3;
	localparam int YDAY_W  = 9;
	localparam int WEEK_W  = 6;

	// Year offset from the epoch, and width of the raw count / 365 estimate
	localparam int OFF_W = $clog2(YEAR_SPAN + 1);
	localparam int EST_W = $clog2((1 << COUNT_W) / 365 + 1);

	localparam int DAYS_PER_WEEK = 7;
	localparam int LAST_YEAR     = BASE_YEAR + YEAR_SPAN - 1;
	localparam int LEAPS_BEFORE_EPOCH =
		(BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100 + (BASE_YEAR - 1) / 400;
	// Days from January 1 of the epoch year to January 1 after the span
	localparam int SPAN_DAYS = YEAR_SPAN * 365
		+ (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400) - LEAPS_BEFORE_EPOCH;

	typedef enum logic {
		REQ_DATE_TO_COUNT = 1'b0,
		REQ_COUNT_TO_DATE = 1'b1
	} req_t;

	// Input beat as registered at the slave side
	typedef struct packed {
		req_t               req;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [COUNT_W-1:0] count;
	} req_beat_t;

	// After range checks and year estimate
	typedef struct packed {
		req_t               req;
		logic               ok;
		logic [OFF_W-1:0]   off;
		logic [YDAY_W-1:0]  yday;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [COUNT_W-1:0] count;
	} chk_t;

	// After the year is settled: final count and day of year
	typedef struct packed {
		req_t               req;
		logic               ok;
		logic [OFF_W-1:0]   off;
		logic [COUNT_W-1:0] count;
		logic [YDAY_W-1:0]  yday;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} pos_t;

	// Full date plus residues mod 7
	typedef struct packed {
		logic               ok;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [COUNT_W-1:0] count;
		logic [YDAY_W-1:0]  yday;
		logic [WDAY_W-1:0]  cmod;
		logic [WDAY_W-1:0]  ymod;
	} cal_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic [YDAY_W-1:0]  yday;
		logic [WEEK_W-1:0]  week;
		logic               valid;
	} result_t;

	// y / 100 by reciprocal, exact for any 12-bit year
	function automatic logic [5:0] div100(input logic [YEAR_W-1:0] y);
		logic [24:0] p;
		p = 25'(y) * 25'(5243);
		return p[24:19];
	endfunction

	// Gregorian leap rule; y % 400 == 0 is y % 100 == 0 with (y / 100) % 4 == 0
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [5:0]  q;
		logic [12:0] back;
		logic        cent;
		q    = div100(y);
		back = 13'(q) * 13'(100);
		cent = (back[YEAR_W-1:0] == y);
		return ((y[1:0] == 2'd0) && !cent) || (cent && (q[1:0] == 2'd0));
	endfunction

	// Leap years from year 1 through year n
	function automatic logic [9:0] leaps_through(input logic [YEAR_W-1:0] n);
		logic [5:0] q;
		q = div100(n);
		return 10'(n >> 2) - 10'(q) + 10'(q >> 2);
	endfunction

	// Days from January 1 of the epoch year to January 1 of epoch + off
	function automatic logic [COUNT_W-1:0] days_before(input logic [OFF_W-1:0] off);
		logic [YEAR_W-1:0] y1;
		y1 = YEAR_W'(BASE_YEAR - 1) + YEAR_W'(off);
		return COUNT_W'(off) * COUNT_W'(365) + COUNT_W'(leaps_through(y1))
			- COUNT_W'(LEAPS_BEFORE_EPOCH);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Days of the year before the first of month m
	function automatic logic [YDAY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [YDAY_W-1:0] base;
		case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((leap && (m >= 4'd3)) ? 9'd1 : 9'd0);
	endfunction

	// count / 365 by reciprocal, exact over the 17-bit range
	function automatic logic [EST_W-1:0] div365(input logic [COUNT_W-1:0] c);
		logic [32:0] p;
		p = 33'(c) * 33'(45965);
		return p[24+EST_W-1:24];
	endfunction

	// count % 7 through a reciprocal quotient
	function automatic logic [WDAY_W-1:0] mod7_count(input logic [COUNT_W-1:0] c);
		logic [34:0]        p;
		logic [14:0]        q;
		logic [COUNT_W-1:0] qx7;
		logic [COUNT_W-1:0] r;
		p   = 35'(c) * 35'(149797);
		q   = p[34:20];
		qx7 = COUNT_W'({q, 3'b000}) - COUNT_W'(q);
		r   = c - qx7;
		return r[WDAY_W-1:0];
	endfunction

	// x / 7 for values below 512
	function automatic logic [6:0] div7_small(input logic [YDAY_W-1:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'(293);
		return p[17:11];
	endfunction

	function automatic logic [WDAY_W-1:0] mod7_small(input logic [YDAY_W-1:0] x);
		logic [6:0]        q;
		logic [YDAY_W-1:0] r;
		q = div7_small(x);
		r = x - (YDAY_W'({q, 3'b000}) - YDAY_W'(q));
		return r[WDAY_W-1:0];
	endfunction

endpackage

[sv/calendar_date_converter.sv]
`timescale 1ns / 1ps
// Top level of the calendar date converter: input register, four stages, handshake.
// Depends on cdc_pkg, cdc_check_stage, cdc_year_stage, cdc_month_stage, cdc_week_stage.
//
// Use:
//   Slave stream: one request per beat. tuser holds the request type (0 converts
//   year/month/day to a day count since January 1 of the epoch year, 1 converts a
//   day count back to a date). Fields a request type does not use are ignored.
//   Master stream: one result per request, in order. tuser is the valid flag;
//   when it is low the request was out of span or not a real date and tdata is 0.
// Timing:
//   An accepted beat passes the input register, then the check, year, month and
//   week registers, to the master side. Throughput is one beat per cycle while the
//   master side takes results; the four register stages hold one constant-divisor
//   step each (year estimate, start-of-year count, month search, week math).
// Reset:
//   All stage valid flags clear; no result is pending and tready rises at once.
// Stall:
//   Each stage loads whenever it is empty or the stage after it moves, so
//   tready stays high unless every stage, the output register included, holds a beat and m_axis_tready is low.
module calendar_date_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [11:0] year_in, [15:12] month_in, [20:16] day_in, [37:21] count_in, [39:38] zero
	input  logic [39:0] s_axis_tdata,
	// [0] req_type
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [16:0] count_out, [28:17] year_out, [32:29] month_out, [37:33] day_out,
	// [40:38] weekday, [49:41] year_day, [55:50] week_number
	output logic [55:0] m_axis_tdata,
	// [0] valid_res
	output logic [0:0]  m_axis_tuser
);

	logic               en_s1, en_s2, en_s3, en_s4, en_s5;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	cdc_pkg::req_beat_t beat_s1;
	cdc_pkg::chk_t      chk_s2;
	cdc_pkg::pos_t      pos_s3;
	cdc_pkg::cal_t      cal_s4;
	cdc_pkg::result_t   res_s5;

	// Per-stage load enables; bubbles collapse while the output waits
	assign en_s5 = !v_s5 || m_axis_tready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			beat_s1.req   <= cdc_pkg::req_t'(s_axis_tuser[0]);
			beat_s1.year  <= s_axis_tdata[11:0];
			beat_s1.month <= s_axis_tdata[15:12];
			beat_s1.day   <= s_axis_tdata[20:16];
			beat_s1.count <= s_axis_tdata[37:21];
		end
	end

	cdc_check_stage u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s2),
		.in_valid  (v_s1),
		.in_beat   (beat_s1),
		.out_valid (v_s2),
		.out_beat  (chk_s2)
	);

	cdc_year_stage u_year (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s3),
		.in_valid  (v_s2),
		.in_beat   (chk_s2),
		.out_valid (v_s3),
		.out_beat  (pos_s3)
	);

	cdc_month_stage u_month (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s4),
		.in_valid  (v_s3),
		.in_beat   (pos_s3),
		.out_valid (v_s4),
		.out_beat  (cal_s4)
	);

	cdc_week_stage u_week (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s5),
		.in_valid  (v_s4),
		.in_beat   (cal_s4),
		.out_valid (v_s5),
		.out_beat  (res_s5)
	);

	// Master side
	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {res_s5.week, res_s5.yday, res_s5.weekday, res_s5.day,
		res_s5.month, res_s5.year, res_s5.count};
	assign m_axis_tuser  = res_s5.valid;

`ifndef NO_ASSERTIONS
	// An accepted beat always lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted beat not captured");

	// Backpressure reaches the slave side only when every stage is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !m_axis_tready)
		else $error("slave stalled with a free stage");

	// A rejected request carries an all-zero payload
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res_s5.valid |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero payload");

	// A valid result is a real calendar position
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_s5.valid |->
			res_s5.month >= 4'd1 && res_s5.month <= 4'd12 && res_s5.day != 5'd0
			&& res_s5.weekday <= 3'd6 && res_s5.yday <= 9'd365
			&& res_s5.week >= 6'd1 && res_s5.week <= 6'd54)
		else $error("valid result out of calendar range");
`endif

endmodule

[sv/cdc_check_stage.sv]
`timescale 1ns / 1ps
// Range and month-length checks, day of year for dates, year estimate for counts.
// Depends on cdc_pkg.
module cdc_check_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cdc_pkg::req_beat_t in_beat,
	output logic              out_valid,
	output cdc_pkg::chk_t     out_beat
);

	logic                          leap;
	logic                          date_ok;
	logic                          cnt_ok;
	logic [cdc_pkg::EST_W-1:0]     est;
	logic [cdc_pkg::OFF_W-1:0]     off_est;
	logic [cdc_pkg::OFF_W-1:0]     off_date;
	logic [cdc_pkg::YDAY_W-1:0]    yday_date;
	cdc_pkg::chk_t                 nxt;

	// Date request: year span, month code, day within the month
	always_comb begin
		leap    = cdc_pkg::is_leap(in_beat.year);
		date_ok = (in_beat.year >= cdc_pkg::YEAR_W'(cdc_pkg::BASE_YEAR))
			&& (in_beat.year <= cdc_pkg::YEAR_W'(cdc_pkg::LAST_YEAR))
			&& (in_beat.month >= 4'd1) && (in_beat.month <= 4'd12)
			&& (in_beat.day != 5'd0)
			&& (in_beat.day <= cdc_pkg::month_len(in_beat.month, leap));
		off_date  = cdc_pkg::OFF_W'(in_beat.year - cdc_pkg::YEAR_W'(cdc_pkg::BASE_YEAR));
		yday_date = cdc_pkg::month_start(in_beat.month, leap)
			+ cdc_pkg::YDAY_W'(in_beat.day) - 9'd1;
	end

	// Count request: span check and a year estimate that never falls short
	always_comb begin
		cnt_ok = (in_beat.count < cdc_pkg::COUNT_W'(cdc_pkg::SPAN_DAYS));
		est    = cdc_pkg::div365(in_beat.count);
		if (est > cdc_pkg::EST_W'(cdc_pkg::YEAR_SPAN - 1)) begin
			off_est = cdc_pkg::OFF_W'(cdc_pkg::YEAR_SPAN - 1);
		end else begin
			off_est = cdc_pkg::OFF_W'(est);
		end
	end

	always_comb begin
		nxt.req   = in_beat.req;
		nxt.ok    = (in_beat.req == cdc_pkg::REQ_COUNT_TO_DATE) ? cnt_ok : date_ok;
		nxt.off   = (in_beat.req == cdc_pkg::REQ_COUNT_TO_DATE) ? off_est : off_date;
		nxt.yday  = yday_date;
		nxt.month = in_beat.month;
		nxt.day   = in_beat.day;
		nxt.count = in_beat.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_beat <= nxt;
		end
	end

endmodule

[sv/cdc_year_stage.sv]
`timescale 1ns / 1ps
// Day count at the start of the year; settles the year estimate for counts.
// Depends on cdc_pkg.
module cdc_year_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  cdc_pkg::chk_t in_beat,
	output logic          out_valid,
	output cdc_pkg::pos_t out_beat
);

	logic [cdc_pkg::COUNT_W-1:0] db;
	logic [cdc_pkg::COUNT_W-1:0] db_prev;
	logic [cdc_pkg::OFF_W-1:0]   off_prev;
	logic                        step;
	logic [cdc_pkg::COUNT_W-1:0] base;
	logic [cdc_pkg::COUNT_W-1:0] rem;
	cdc_pkg::pos_t               nxt;

	// Estimate and the year before it, in parallel; at most one step down
	always_comb begin
		off_prev = in_beat.off - cdc_pkg::OFF_W'(1);
		db       = cdc_pkg::days_before(in_beat.off);
		db_prev  = cdc_pkg::days_before(off_prev);
		step     = (db > in_beat.count) && (in_beat.off != '0);
		base     = step ? db_prev : db;
		rem      = in_beat.count - base;
	end

	always_comb begin
		nxt.req   = in_beat.req;
		nxt.ok    = in_beat.ok;
		nxt.month = in_beat.month;
		nxt.day   = in_beat.day;
		if (in_beat.req == cdc_pkg::REQ_COUNT_TO_DATE) begin
			nxt.off   = step ? off_prev : in_beat.off;
			nxt.count = in_beat.count;
			nxt.yday  = rem[cdc_pkg::YDAY_W-1:0];
		end else begin
			nxt.off   = in_beat.off;
			nxt.count = db + cdc_pkg::COUNT_W'(in_beat.yday);
			nxt.yday  = in_beat.yday;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_beat <= nxt;
		end
	end

endmodule

[sv/cdc_month_stage.sv]
`timescale 1ns / 1ps
// Month and day from day of year for counts; residues mod 7 for the week math.
// Depends on cdc_pkg.
module cdc_month_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  cdc_pkg::pos_t in_beat,
	output logic          out_valid,
	output cdc_pkg::cal_t out_beat
);

	logic [cdc_pkg::YEAR_W-1:0]  year;
	logic                        leap;
	logic [cdc_pkg::MONTH_W-1:0] mon;
	logic [cdc_pkg::YDAY_W-1:0]  into_mon;
	cdc_pkg::cal_t               nxt;

	// Last month whose first day is not past the day of year
	always_comb begin
		year = cdc_pkg::YEAR_W'(cdc_pkg::BASE_YEAR) + cdc_pkg::YEAR_W'(in_beat.off);
		leap = cdc_pkg::is_leap(year);
		mon  = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (in_beat.yday >= cdc_pkg::month_start(cdc_pkg::MONTH_W'(k), leap)) begin
				mon = cdc_pkg::MONTH_W'(k);
			end
		end
		into_mon = in_beat.yday - cdc_pkg::month_start(mon, leap);
	end

	always_comb begin
		nxt.ok    = in_beat.ok;
		nxt.year  = year;
		nxt.count = in_beat.count;
		nxt.yday  = in_beat.yday;
		nxt.cmod  = cdc_pkg::mod7_count(in_beat.count);
		nxt.ymod  = cdc_pkg::mod7_small(in_beat.yday);
		if (in_beat.req == cdc_pkg::REQ_COUNT_TO_DATE) begin
			nxt.month = mon;
			nxt.day   = cdc_pkg::DAY_W'(into_mon) + 5'd1;
		end else begin
			nxt.month = in_beat.month;
			nxt.day   = in_beat.day;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_beat <= nxt;
		end
	end

endmodule

[sv/cdc_week_stage.sv]
`timescale 1ns / 1ps
// Weekday and Sunday-start week number; zeroes the result of an invalid request.
// Depends on cdc_pkg. Its register is the master-side output register.
module cdc_week_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  cdc_pkg::cal_t    in_beat,
	output logic             out_valid,
	output cdc_pkg::result_t out_beat
);

	logic [3:0]                 wd_sum;
	logic [cdc_pkg::WDAY_W-1:0] wd;
	logic [3:0]                 jan_sum;
	logic [cdc_pkg::WDAY_W-1:0] wd_jan1;
	logic [cdc_pkg::YDAY_W-1:0] wk_days;
	cdc_pkg::result_t           nxt;

	// Weekday of the date, then weekday of January 1, then the week index
	always_comb begin
		wd_sum = 4'(cdc_pkg::EPOCH_WEEKDAY) + {1'b0, in_beat.cmod};
		wd = (wd_sum >= 4'(cdc_pkg::DAYS_PER_WEEK))
			? cdc_pkg::WDAY_W'(wd_sum - 4'(cdc_pkg::DAYS_PER_WEEK))
			: cdc_pkg::WDAY_W'(wd_sum);
		jan_sum = {1'b0, wd} + 4'(cdc_pkg::DAYS_PER_WEEK) - {1'b0, in_beat.ymod};
		wd_jan1 = (jan_sum >= 4'(cdc_pkg::DAYS_PER_WEEK))
			? cdc_pkg::WDAY_W'(jan_sum - 4'(cdc_pkg::DAYS_PER_WEEK))
			: cdc_pkg::WDAY_W'(jan_sum);
		wk_days = in_beat.yday + cdc_pkg::YDAY_W'(wd_jan1);
	end

	always_comb begin
		if (in_beat.ok) begin
			nxt.count   = in_beat.count;
			nxt.year    = in_beat.year;
			nxt.month   = in_beat.month;
			nxt.day     = in_beat.day;
			nxt.weekday = wd;
			nxt.yday    = in_beat.yday;
			nxt.week    = cdc_pkg::WEEK_W'(cdc_pkg::div7_small(wk_days)) + 6'd1;
			nxt.valid   = 1'b1;
		end else begin
			nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_beat <= nxt;
		end
	end

endmodule

[tb/calendar_checker.sv]
`timescale 1ns / 1ps
// Checker for calendar_date_converter: watches both stream channels, predicts each result.
// Depends on cdc_pkg for the request enum, the epoch constants and the field widths.
module calendar_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	output int          mismatches,
	output int          pending,
	output int          results_seen,
	output int          invalid_seen
);

	localparam int FIRST_YEAR = cdc_pkg::BASE_YEAR;
	localparam int FINAL_YEAR = cdc_pkg::BASE_YEAR + cdc_pkg::YEAR_SPAN - 1;

	typedef struct packed {
		logic [cdc_pkg::COUNT_W-1:0] count;
		logic [cdc_pkg::YEAR_W-1:0]  year;
		logic [cdc_pkg::MONTH_W-1:0] month;
		logic [cdc_pkg::DAY_W-1:0]   day;
		logic [cdc_pkg::WDAY_W-1:0]  weekday;
		logic [cdc_pkg::YDAY_W-1:0]  yday;
		logic [cdc_pkg::WEEK_W-1:0]  week;
		logic                        valid;
	} date_answer_t;

	date_answer_t expected_answers[$];

	function automatic bit leap_year(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(int m, int y);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// leap years in 1..n
	function automatic int leaps_upto(int n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	// day count of January 1 of year y
	function automatic int jan1_count(int y);
		return (y - FIRST_YEAR) * 365 + leaps_upto(y - 1) - leaps_upto(FIRST_YEAR - 1);
	endfunction

	function automatic date_answer_t predict_conversion(cdc_pkg::req_t kind,
			logic [11:0] yr, logic [3:0] mo, logic [4:0] dy, logic [16:0] cnt);
		date_answer_t a;
		int y, m, d, c, yd, wd, wd_jan1, i;
		a = '0;
		if (kind == cdc_pkg::REQ_DATE_TO_COUNT) begin
			y = int'(yr);
			m = int'(mo);
			d = int'(dy);
			if (y < FIRST_YEAR || y > FINAL_YEAR || m < 1 || m > 12)
				return a;
			if (d < 1 || d > days_in_month(m, y))
				return a;
			yd = d - 1;
			for (i = 1; i < m; i++)
				yd += days_in_month(i, y);
			c = jan1_count(y) + yd;
		end else begin
			c = int'(cnt);
			if (c >= jan1_count(FINAL_YEAR + 1))
				return a;
			// walk years forward from the epoch
			y = FIRST_YEAR;
			while (jan1_count(y + 1) <= c)
				y++;
			yd = c - jan1_count(y);
			d = yd;
			m = 1;
			while (d >= days_in_month(m, y)) begin
				d -= days_in_month(m, y);
				m++;
			end
			d = d + 1;
		end
		wd = (cdc_pkg::EPOCH_WEEKDAY + c % 7) % 7;
		wd_jan1 = (wd + 7 - yd % 7) % 7;
		a.count   = cdc_pkg::COUNT_W'(c);
		a.year    = cdc_pkg::YEAR_W'(y);
		a.month   = cdc_pkg::MONTH_W'(m);
		a.day     = cdc_pkg::DAY_W'(d);
		a.weekday = cdc_pkg::WDAY_W'(wd);
		a.yday    = cdc_pkg::YDAY_W'(yd);
		a.week    = cdc_pkg::WEEK_W'((yd + wd_jan1) / 7 + 1);
		a.valid   = 1'b1;
		return a;
	endfunction

	// one line per mismatch, and the count
	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic compare_field(string field, int got, int want);
		if (got != want)
			report_mismatch($sformatf("result %0d: %s is %0d, wanted %0d",
				results_seen, field, got, want));
	endtask

	// input beats push a prediction, output beats pop and compare
	always @(posedge clk or negedge arst_n) begin
		date_answer_t want;
		if (!arst_n) begin
			expected_answers.delete();
			pending = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_answers.push_back(predict_conversion(
					cdc_pkg::req_t'(s_axis_tuser[0]), s_axis_tdata[11:0],
					s_axis_tdata[15:12], s_axis_tdata[20:16], s_axis_tdata[37:21]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat, tdata %h",
						m_axis_tdata));
				end else begin
					want = expected_answers.pop_front();
					compare_field("count_out", int'(m_axis_tdata[16:0]), int'(want.count));
					compare_field("year_out", int'(m_axis_tdata[28:17]), int'(want.year));
					compare_field("month_out", int'(m_axis_tdata[32:29]), int'(want.month));
					compare_field("day_out", int'(m_axis_tdata[37:33]), int'(want.day));
					compare_field("weekday", int'(m_axis_tdata[40:38]), int'(want.weekday));
					compare_field("year_day", int'(m_axis_tdata[49:41]), int'(want.yday));
					compare_field("week_number", int'(m_axis_tdata[55:50]),
						int'(want.week));
					compare_field("valid_res", int'(m_axis_tuser[0]), int'(want.valid));
					if (!want.valid)
						invalid_seen++;
				end
				results_seen++;
			end
			pending = expected_answers.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for calendar_date_converter: clock, reset, request stimulus and verdict.
// Depends on cdc_pkg, the converter RTL and calendar_checker.
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 1900;
	localparam int SPAN_COUNT = cdc_pkg::SPAN_DAYS;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	int mismatches, pending, results_seen, invalid_seen;
	int src_idle_pct = 17;
	int rx_idle_pct = 79;
	int cycle_count = 0;
	int date_reqs = 0;
	int count_reqs = 0;

	always #5 clk = ~clk;

	calendar_date_converter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	calendar_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending),
		.results_seen  (results_seen),
		.invalid_seen  (invalid_seen)
	);

	// result-side backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one request beat, with random idle cycles ahead of it
	task automatic send_request(cdc_pkg::req_t kind, int yr, int mo, int dy, int cnt);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, 17'(cnt), 5'(dy), 4'(mo), 12'(yr)};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (kind == cdc_pkg::REQ_DATE_TO_COUNT)
			date_reqs++;
		else
			count_reqs++;
	endtask

	// day count of January 1 of year y, for aiming at year boundaries
	function automatic int year_start_count(int y);
		int acc, k;
		acc = 0;
		for (k = cdc_pkg::BASE_YEAR; k < y; k++)
			acc += (((k % 4 == 0) && (k % 100 != 0)) || (k % 400 == 0)) ? 366 : 365;
		return acc;
	endfunction

	task automatic send_random_request();
		int sel, yr;
		sel = $urandom_range(99);
		yr = cdc_pkg::BASE_YEAR + $urandom_range(cdc_pkg::YEAR_SPAN - 1);
		if (sel < 40) begin
			// in-span date, often near a month end
			send_request(cdc_pkg::REQ_DATE_TO_COUNT, yr, $urandom_range(1, 12),
				($urandom_range(1) != 0) ? $urandom_range(1, 28) : $urandom_range(28, 31),
				$urandom);
		end else if (sel < 50) begin
			send_request(cdc_pkg::REQ_DATE_TO_COUNT, $urandom, $urandom, $urandom,
				$urandom);
		end else if (sel < 78) begin
			send_request(cdc_pkg::REQ_COUNT_TO_DATE, $urandom, $urandom, $urandom,
				$urandom_range(SPAN_COUNT - 1));
		end else if (sel < 92) begin
			// just around January 1, including the end of the span
			send_request(cdc_pkg::REQ_COUNT_TO_DATE, $urandom, $urandom, $urandom,
				year_start_count(yr + 1) + $urandom_range(2) - 1);
		end else begin
			send_request(cdc_pkg::REQ_COUNT_TO_DATE, $urandom, $urandom, $urandom,
				$urandom);
		end
	endtask

	initial begin
		int i, phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: span edges, leap rules, bad fields, year-boundary counts
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 1970, 1, 1, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 2225, 12, 31, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 1969, 12, 31, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 2226, 1, 1, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 0, 0, 0, 17'h1FFFF);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 4095, 15, 31, 17'h1FFFF);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 2000, 2, 29, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 2100, 2, 29, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 2024, 2, 29, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 1970, 2, 29, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 1999, 4, 31, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 1999, 13, 1, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 1999, 12, 0, 0);
		send_request(cdc_pkg::REQ_DATE_TO_COUNT, 2000, 12, 31, 0);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 0);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 4095, 15, 31, 364);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 365);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 1460);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 1461);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 10956);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 10957);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, SPAN_COUNT - 1);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 4095, 15, 31, SPAN_COUNT);
		send_request(cdc_pkg::REQ_COUNT_TO_DATE, 0, 0, 0, 17'h1FFFF);

		// random: slow receiver, then slow sender, then full rate
		for (phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 79 : 0;
			rx_idle_pct  = (phase == 0) ? 79 : (phase == 1) ? 17 : 0;
			for (i = 0; i < RANDOM_BEATS / 3; i++)
				send_random_request();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		// drain, then give the pipeline time to show any stray beat
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Sent %0d date-to-count and %0d count-to-date requests", date_reqs,
			count_reqs);
		$display("Checked %0d results, %0d of them out of span or not a date",
			results_seen, invalid_seen);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/cdc_pkg.sv
sv/cdc_check_stage.sv
sv/cdc_year_stage.sv
sv/cdc_month_stage.sv
sv/cdc_week_stage.sv
sv/calendar_date_converter.sv
tb/calendar_checker.sv
tb/tb_top.sv
